// File: rtl/core/i2c_slave_light_register_assert.svh
// Assertion macros used by the light register I2C slave RTL.
`ifndef I2C_SLAVE_LIGHT_REGISTER_ASSERT_SVH
`define I2C_SLAVE_LIGHT_REGISTER_ASSERT_SVH

// Same-cycle implication, checked on i_clk, dropped during reset.
`define I2CSL_ASSERT_IMPLY(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("i2c slave: same-cycle check failed");

// Next-cycle implication, checked on i_clk, dropped during reset.
`define I2CSL_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("i2c slave: next-cycle check failed");

`endif

// File: rtl/core/i2csl_pkg.sv
// Package with widths, register indexes and reset constants of the I2C slave.
`timescale 1ns / 1ps
`default_nettype none
package i2csl_pkg;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ADDR_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int BIT_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_TYPE_CODE      = 2'd1
    } t_cfg_idx;

    localparam logic [BYTE_W-1:0]    DUTY_RESET    = 8'd30;
    localparam logic [ADDR_W-1:0]    ADDR_RESET    = 7'd1;
    localparam logic [BYTE_W-1:0]    TYPE_RESET    = 8'd0;
    localparam logic [BIT_IDX_W-1:0] BIT_IDX_FIRST = 3'd7;
    localparam logic [BYTE_W-1:0]    TOP_BIT       = 8'h80;
endpackage
`default_nettype wire

// File: rtl/core/i2c_slave_light_register.sv
// Top level: oversampled I2C slave holding one light duty byte.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_scl_level, i_sda_level
//  out     | out       | o_out_valid / i_out_ready  | o_sda_pull_low, o_duty_value,
//          |           |                            | o_duty_updated
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One line sample per cycle unless the output stalls: an accepted sample's result appears
// in the output register on the next cycle.
// The bus phase tracker and the output register advance together on each accepted sample.
// Reset (synchronous, active low) returns the tracker to idle with both lines high,
// duty to 30 and the data line released; the output register empties.
// A stalled output holds its result and blocks the input only while it stays full and unread.
`timescale 1ns / 1ps
`default_nettype none
module i2c_slave_light_register (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // sample channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_scl_level,
    input  wire logic                            i_sda_level,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_sda_pull_low,
    output logic [i2csl_pkg::BYTE_W-1:0]         o_duty_value,
    output logic                                 o_duty_updated,
    // configuration channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [i2csl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [i2csl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Bus phases; the letters after the group name tell which lines were last seen high.
    typedef enum logic [4:0] {
        P_IDLE_HIGH, P_IDLE_SDA, P_IDLE_SCL, P_IDLE_LOW,
        P_RD_HIGH, P_RD_SCL, P_RD_SDA, P_RD_LOW,
        P_AMW_HIGH, P_AMW_SCL, P_AMW_LOW, P_AMW_DONE,
        P_ACK_HIGH, P_ACK_SCL, P_ACK_LOW, P_ACK_DONE,
        P_WR_HIGH_IN, P_WR_SCL_IN, P_WR_SDA_IN, P_WR_LOW_IN,
        P_TX_HIGH, P_TX_LOW, P_TX_LAST,
        P_AR_SDA, P_AR_LOW
    } t_phase;

    // configuration
    logic [i2csl_pkg::ADDR_W-1:0]    r_dev_addr;
    logic [i2csl_pkg::BYTE_W-1:0]    r_type_code;

    // bus tracker state
    t_phase                          r_phase,     n_phase;
    logic [i2csl_pkg::BYTE_W-1:0]    r_shift,     n_shift;
    logic [i2csl_pkg::BIT_IDX_W-1:0] r_bit_idx,   n_bit_idx;
    logic [i2csl_pkg::BYTE_W-1:0]    r_duty,      n_duty;
    logic                            r_drive_low, n_drive_low;
    logic                            n_upd;

    // output register
    logic                            r_out_valid;
    logic                            r_out_pull_low;
    logic [i2csl_pkg::BYTE_W-1:0]    r_out_duty;
    logic                            r_out_upd;

    logic                            in_take;
    logic                            cfg_take;

    // Accept a new sample whenever the result register is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_take  = i_in_valid && o_in_ready;
    assign cfg_take = i_cfg_valid && o_cfg_ready;

    assign o_out_valid    = r_out_valid;
    assign o_sda_pull_low = r_out_pull_low;
    assign o_duty_value   = r_out_duty;
    assign o_duty_updated = r_out_upd;

    // Helpers for the bit counter and the address match.
    logic                            bit_last;
    logic [i2csl_pkg::BIT_IDX_W-1:0] bit_dec;
    logic [i2csl_pkg::BYTE_W-1:0]    shift_set;
    logic [i2csl_pkg::BYTE_W-1:0]    bit_mask;
    logic [i2csl_pkg::BYTE_W-1:0]    addr_rd;
    logic [i2csl_pkg::BYTE_W-1:0]    addr_wr;

    assign bit_last  = (r_bit_idx == '0);
    assign bit_dec   = r_bit_idx - 1'b1;
    assign bit_mask  = i2csl_pkg::BYTE_W'(1) << r_bit_idx;
    assign shift_set = r_shift | bit_mask;
    assign addr_rd   = {r_dev_addr, 1'b1};
    assign addr_wr   = {r_dev_addr, 1'b0};

    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_bit_idx   = r_bit_idx;
        n_duty      = r_duty;
        n_drive_low = r_drive_low;
        n_upd       = 1'b0;
        case (r_phase)
            P_IDLE_HIGH: begin
                // Start: data falls while clock stays high.
                if (!i_sda_level) begin
                    n_shift   = '0;
                    n_bit_idx = i2csl_pkg::BIT_IDX_FIRST;
                    n_phase   = P_RD_SCL;
                end else if (!i_scl_level) begin
                    n_phase = P_IDLE_SDA;
                end
            end
            P_IDLE_SCL: begin
                if (i_sda_level)       n_phase = P_IDLE_HIGH;
                else if (!i_scl_level) n_phase = P_IDLE_LOW;
            end
            P_IDLE_SDA: begin
                if (!i_sda_level)     n_phase = P_IDLE_LOW;
                else if (i_scl_level) n_phase = P_IDLE_HIGH;
            end
            P_IDLE_LOW: begin
                if (i_sda_level)      n_phase = P_IDLE_SDA;
                else if (i_scl_level) n_phase = P_IDLE_SCL;
            end
            P_RD_LOW: begin
                // Clock rises on a zero address bit.
                if (i_scl_level) begin
                    n_bit_idx = bit_dec;
                    if (!bit_last) begin
                        n_phase = P_RD_SCL;
                    end else if (r_shift == addr_rd) begin
                        n_bit_idx = i2csl_pkg::BIT_IDX_FIRST;
                        n_shift   = r_type_code;
                        n_phase   = P_ACK_SCL;
                    end else if (r_shift == addr_wr) begin
                        n_bit_idx = i2csl_pkg::BIT_IDX_FIRST;
                        n_shift   = '0;
                        n_phase   = P_AMW_SCL;
                    end else begin
                        n_phase = P_IDLE_SCL;
                    end
                end else if (i_sda_level) begin
                    n_phase = P_RD_SDA;
                end
            end
            P_RD_HIGH: begin
                if (!i_scl_level)      n_phase = P_RD_SDA;
                else if (!i_sda_level) n_phase = P_RD_SCL;
            end
            P_RD_SCL: begin
                if (!i_scl_level)     n_phase = P_RD_LOW;
                else if (i_sda_level) n_phase = P_RD_HIGH;
            end
            P_RD_SDA: begin
                // Clock rises on a one address bit.
                if (i_scl_level) begin
                    n_shift   = shift_set;
                    n_bit_idx = bit_dec;
                    if (!bit_last) begin
                        n_phase = P_RD_HIGH;
                    end else if (shift_set == addr_rd) begin
                        n_bit_idx = i2csl_pkg::BIT_IDX_FIRST;
                        n_shift   = r_type_code;
                        n_phase   = P_ACK_HIGH;
                    end else if (shift_set == addr_wr) begin
                        n_bit_idx = i2csl_pkg::BIT_IDX_FIRST;
                        n_shift   = '0;
                        n_phase   = P_AMW_HIGH;
                    end else begin
                        n_phase = P_IDLE_HIGH;
                    end
                end else if (!i_sda_level) begin
                    n_phase = P_RD_LOW;
                end
            end
            P_AMW_HIGH: begin
                if (!i_scl_level) begin
                    n_drive_low = 1'b1;
                    n_phase     = P_AMW_LOW;
                end else if (!i_sda_level) begin
                    n_phase = P_IDLE_SCL;
                end
            end
            P_AMW_SCL: begin
                if (!i_scl_level) begin
                    n_drive_low = 1'b1;
                    n_phase     = P_AMW_LOW;
                end else if (i_sda_level) begin
                    n_phase = P_IDLE_HIGH;
                end
            end
            P_AMW_LOW: begin
                if (i_scl_level) n_phase = P_AMW_DONE;
            end
            P_AMW_DONE: begin
                if (!i_scl_level) begin
                    n_drive_low = 1'b0;
                    n_phase     = P_WR_SDA_IN;
                end
            end
            P_ACK_HIGH: begin
                if (!i_scl_level) begin
                    n_drive_low = 1'b1;
                    n_phase     = P_ACK_LOW;
                end else if (!i_sda_level) begin
                    n_phase = P_IDLE_SCL;
                end
            end
            P_ACK_SCL: begin
                if (!i_scl_level) begin
                    n_drive_low = 1'b1;
                    n_phase     = P_ACK_LOW;
                end else if (i_sda_level) begin
                    n_phase = P_IDLE_HIGH;
                end
            end
            P_ACK_LOW: begin
                if (i_scl_level) n_phase = P_ACK_DONE;
            end
            P_ACK_DONE: begin
                // Put the top bit of the byte to send on the line.
                if (!i_scl_level) begin
                    n_drive_low = ((r_shift & i2csl_pkg::TOP_BIT) == '0);
                    n_phase     = P_TX_LOW;
                end
            end
            P_WR_LOW_IN: begin
                if (i_scl_level) begin
                    n_bit_idx = bit_dec;
                    if (bit_last) begin
                        n_duty  = r_shift;
                        n_upd   = 1'b1;
                        n_phase = P_IDLE_SCL;
                    end else begin
                        n_phase = P_WR_SCL_IN;
                    end
                end else if (i_sda_level) begin
                    n_phase = P_WR_SDA_IN;
                end
            end
            P_WR_HIGH_IN: begin
                if (!i_scl_level)      n_phase = P_WR_SDA_IN;
                else if (!i_sda_level) n_phase = P_WR_SCL_IN;
            end
            P_WR_SCL_IN: begin
                if (!i_scl_level)     n_phase = P_WR_LOW_IN;
                else if (i_sda_level) n_phase = P_WR_HIGH_IN;
            end
            P_WR_SDA_IN: begin
                if (i_scl_level) begin
                    n_shift   = shift_set;
                    n_bit_idx = bit_dec;
                    if (bit_last) begin
                        n_duty  = shift_set;
                        n_upd   = 1'b1;
                        n_phase = P_IDLE_HIGH;
                    end else begin
                        n_phase = P_WR_HIGH_IN;
                    end
                end else if (!i_sda_level) begin
                    n_phase = P_WR_LOW_IN;
                end
            end
            P_TX_HIGH: begin
                if (!i_scl_level) begin
                    n_drive_low = ((r_shift & bit_mask) == '0);
                    n_phase     = P_TX_LOW;
                end
            end
            P_TX_LOW: begin
                if (i_scl_level) begin
                    n_bit_idx = bit_dec;
                    n_phase   = bit_last ? P_TX_LAST : P_TX_HIGH;
                end
            end
            P_TX_LAST: begin
                // Release the line for the master's ack.
                if (!i_scl_level) begin
                    n_drive_low = 1'b0;
                    n_phase     = P_AR_SDA;
                end
            end
            P_AR_SDA: begin
                if (i_scl_level)       n_phase = P_IDLE_HIGH;
                else if (!i_sda_level) n_phase = P_AR_LOW;
            end
            P_AR_LOW: begin
                // Master acked: load the duty byte for the next read byte.
                if (i_scl_level) begin
                    n_shift   = r_duty;
                    n_bit_idx = i2csl_pkg::BIT_IDX_FIRST;
                    n_phase   = P_ACK_DONE;
                end else if (i_sda_level) begin
                    n_phase = P_AR_SDA;
                end
            end
            default: begin
                n_phase = P_IDLE_HIGH;
            end
        endcase
    end

    // State, configuration and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= i2csl_pkg::ADDR_RESET;
            r_type_code <= i2csl_pkg::TYPE_RESET;
            r_phase     <= P_IDLE_HIGH;
            r_shift     <= '0;
            r_bit_idx   <= i2csl_pkg::BIT_IDX_FIRST;
            r_duty      <= i2csl_pkg::DUTY_RESET;
            r_drive_low <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_take) begin
                case (i_cfg_index)
                    i2csl_pkg::CFG_DEVICE_ADDRESS: r_dev_addr  <= i_cfg_data[i2csl_pkg::ADDR_W-1:0];
                    i2csl_pkg::CFG_TYPE_CODE:      r_type_code <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_take) begin
                r_phase     <= n_phase;
                r_shift     <= n_shift;
                r_bit_idx   <= n_bit_idx;
                r_duty      <= n_duty;
                r_drive_low <= n_drive_low;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: loaded with each accepted sample, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_pull_low <= n_drive_low;
            r_out_duty     <= n_duty;
            r_out_upd      <= n_upd;
        end
    end

`include "i2c_slave_light_register_assert.svh"

    // The held result always mirrors the tracker's duty and drive.
    `I2CSL_ASSERT_IMPLY(a_duty_mirror, r_out_valid, r_out_duty == r_duty)
    `I2CSL_ASSERT_IMPLY(a_drive_mirror, r_out_valid, r_out_pull_low == r_drive_low)
    // A duty write always ends in an idle phase with the line released.
    `I2CSL_ASSERT_IMPLY(a_upd_idle, r_out_valid && r_out_upd,
        (r_phase == P_IDLE_HIGH || r_phase == P_IDLE_SCL) && !r_drive_low)
    // Every accepted sample leaves a result behind.
    `I2CSL_ASSERT_NEXT(a_take_result, in_take, r_out_valid)

endmodule
`default_nettype wire
